[design/assert_macros.svh]
// Assertion macros for the checker file of the chunk framer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is asserted.
`define PCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property check that also runs during reset.
`define PCF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pcf_pkg.sv]
// Package for the PNG chunk framer: payload types, queue entry, CRC helpers.
// No dependencies; used by every module of the block.
package pcf_pkg;

  localparam int LENGTH_BITS_DEF = 31;
  localparam int LEN_W = 31;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Positions inside the byte sequence of one queued operation.
  localparam logic [3:0] IDX_FIRST      = 4'd0;
  localparam logic [3:0] IDX_TYPE_FIRST = 4'd4;
  localparam logic [3:0] IDX_TYPE_LAST  = 4'd7;
  localparam logic [3:0] IDX_CRC_FIRST  = 4'd8;
  localparam logic [3:0] IDX_START_END  = 4'd11;
  localparam logic [3:0] IDX_DATA_END   = 4'd4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_ERR   = 2'd2
  } op_kind_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       protocol_error;
  } out_item_t;

  // One classified request handed from the front end to the back end.
  typedef struct packed {
    op_kind_t         kind;
    logic             fin;
    logic [31:0]      word;
    logic [LEN_W-1:0] len;
  } op_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

[design/pcf_front.sv]
// Front end of the chunk framer: accepts requests and classifies them.
// Depends on pcf_pkg; feeds pcf_queue.
module pcf_front #(
  parameter int LENGTH_BITS = pcf_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcf_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output pcf_pkg::op_t      push_op
);
  import pcf_pkg::*;

  logic                   open_r, open_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic [LENGTH_BITS-1:0] len_in;
  logic                   accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;
  assign len_in   = in_data.chunk_length[LENGTH_BITS-1:0];

  always_comb begin
    open_nxt     = open_r;
    remain_nxt   = remain_r;
    push_op.kind = OP_ERR;
    push_op.fin  = 1'b0;
    push_op.word = 32'd0;
    push_op.len  = '0;
    case (in_data.command)
      CMD_START: begin
        if (!open_r) begin
          push_op.kind = OP_START;
          push_op.word = in_data.chunk_type;
          push_op.len  = LEN_W'(len_in);
          if (len_in == '0) begin
            push_op.fin = 1'b1;
          end else begin
            open_nxt   = 1'b1;
            remain_nxt = len_in;
          end
        end
      end
      CMD_DATA: begin
        if (open_r) begin
          push_op.kind = OP_DATA;
          push_op.word = 32'(in_data.data_byte);
          remain_nxt   = remain_r - LENGTH_BITS'(1);
          if (remain_r == LENGTH_BITS'(1)) begin
            push_op.fin = 1'b1;
            open_nxt    = 1'b0;
          end
        end
      end
      default: push_op.kind = OP_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      remain_r <= '0;
    end else if (accept) begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

[design/pcf_queue.sv]
// Short register queue of classified requests between front and back end.
// Depends on pcf_pkg.
module pcf_queue #(
  parameter int DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  pcf_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output pcf_pkg::op_t head_op
);
  import pcf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

[design/pcf_back.sv]
// Back end of the chunk framer: byte sequencer, CRC register, output register.
// Depends on pcf_pkg; takes requests from pcf_queue.
module pcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  pcf_pkg::op_t       head_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pcf_pkg::out_item_t out_data
);
  import pcf_pkg::*;

  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  logic        advance, done, fold;
  logic [31:0] fold_base, crc_inv;
  logic [7:0]  b;
  logic        last_flag, err_flag;

  assign advance = head_valid && (!out_valid_r || !out_stall);
  assign crc_inv = crc_r ^ CRC_INIT;
  assign pop     = advance && done;

  always_comb begin
    b         = 8'd0;
    last_flag = 1'b0;
    err_flag  = 1'b0;
    done      = 1'b0;
    fold      = 1'b0;
    fold_base = crc_r;
    unique case (head_op.kind)
      OP_START: begin
        if (idx_r < IDX_TYPE_FIRST) begin
          b = byte_sel(32'(head_op.len), idx_r[1:0]);
        end else if (idx_r < IDX_CRC_FIRST) begin
          b    = byte_sel(head_op.word, idx_r[1:0]);
          fold = 1'b1;
          if (idx_r == IDX_TYPE_FIRST) begin
            fold_base = CRC_INIT;
          end
          if (idx_r == IDX_TYPE_LAST && !head_op.fin) begin
            done = 1'b1;
          end
        end else begin
          b = byte_sel(crc_inv, idx_r[1:0]);
          if (idx_r == IDX_START_END) begin
            last_flag = 1'b1;
            done      = 1'b1;
          end
        end
      end
      OP_DATA: begin
        if (idx_r == IDX_FIRST) begin
          b    = head_op.word[7:0];
          fold = 1'b1;
          done = !head_op.fin;
        end else begin
          b = byte_sel(crc_inv, 2'(idx_r - 4'd1));
          if (idx_r == IDX_DATA_END) begin
            last_flag = 1'b1;
            done      = 1'b1;
          end
        end
      end
      OP_ERR: begin
        err_flag = 1'b1;
        done     = 1'b1;
      end
      default: done = 1'b1;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      idx_nxt       = done ? IDX_FIRST : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
      if (fold) begin
        crc_nxt = crc_fold(fold_base, b);
      end else if (last_flag) begin
        crc_nxt = CRC_INIT;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_FIRST;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.out_byte       <= b;
      out_data_r.last           <= last_flag;
      out_data_r.protocol_error <= err_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/png_chunk_crc_framer.sv]
// PNG chunk framer with CRC-32: an accepted request is registered in the queue, and
// the back end loads its bytes into the output register. Data bytes pass at one per
// cycle while the output does not stall. A start request sends four length and four
// type bytes, plus four CRC bytes for a zero-length chunk; a closing request sends
// one data byte and four CRC bytes. Synchronous active-low reset empties the queue,
// closes any chunk and presets the CRC to all ones; no clearing pass is needed.
module png_chunk_crc_framer #(
  parameter int LENGTH_BITS = pcf_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pcf_pkg::out_item_t out_data
);
  import pcf_pkg::*;

  // The front end tracks whether a chunk is open and how many data bytes are
  // still owed, so it can classify every request the cycle it arrives. Each
  // request becomes one queue entry: a start, a data byte, or an error. An
  // entry carries a flag that tells the back end to append the CRC bytes.
  logic front_push;
  op_t  front_op;
  logic q_full;

  // The back end walks the head entry's bytes, folds type and data bytes into
  // the CRC one byte per cycle unless the output stalls, and loads the output
  // register. The queue lets requests arrive while header or CRC bytes go out.
  logic q_head_valid;
  op_t  q_head_op;
  logic back_pop;

  pcf_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (front_push),
    .push_op  (front_op)
  );

  pcf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (back_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  pcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .pop        (back_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[design/pcf_checker.sv]
// Port-level checks for the chunk framer, attached to the top level by bind.
// Depends on pcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pcf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pcf_pkg::out_item_t out_data
);
  import pcf_pkg::*;

  `PCF_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_data), "stalled input changed")
  `PCF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled request changed")
  `PCF_ASSERT(a_err_form, clk, rst_n, out_valid && out_data.protocol_error |-> out_data.out_byte == 8'd0 && !out_data.last, "bad error request")
  `PCF_ASSERT_NR(a_rst_out, clk, !rst_n |=> !out_valid, "output valid after reset")
  `PCF_ASSERT_NR(a_rst_in, clk, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind png_chunk_crc_framer pcf_checker u_pcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
